// ===== rtl/core/srle_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srle_pkg
// Shared types and codes for the run-length sprite run decoder.
// ----------------------------------------------------------------------------
package srle_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int COORD_W        = 16;
  localparam int BYTE_W         = 8;
  localparam int MODE_W         = 3;
  localparam int KIND_W         = 2;

  localparam logic [MODE_W-1:0] MODE_CMD        = 3'd0;
  localparam logic [MODE_W-1:0] MODE_LIT        = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SH_FIRST   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SH_COUNT   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CNT_COLOUR = 3'd4;
  localparam logic [MODE_W-1:0] MODE_REPEAT     = 3'd5;

  localparam logic [KIND_W-1:0] KIND_COLOUR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SHADOW = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END    = 2'd2;

  localparam logic [BYTE_W-1:0] CODE_NEWLINE    = 8'h00;
  localparam logic [BYTE_W-1:0] CODE_END        = 8'h80;
  localparam logic [BYTE_W-1:0] CODE_SHADOW     = 8'hC0;
  localparam logic [BYTE_W-1:0] CODE_CNT_COLOUR = 8'hC1;

  typedef struct packed {
    logic [KIND_W-1:0]  run_kind;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [BYTE_W-1:0]  run_length;
    logic [BYTE_W-1:0]  colour_index;
    logic               truncated;
    logic               sprite_done;
  } res_t;

  typedef struct packed {
    logic emit;
    logic close;
  } ctl_t;

endpackage

// ===== rtl/core/srle_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srle_decode
// Next-state and run result logic for one code byte.
// ----------------------------------------------------------------------------
module srle_decode #(
  parameter int COORD_BITS = srle_pkg::COORD_BITS_DEF
) (
  input  logic [srle_pkg::MODE_W-1:0] mode,
  input  logic [srle_pkg::BYTE_W-1:0] pend,
  input  logic [COORD_BITS-1:0]       cursor_x,
  input  logic [COORD_BITS-1:0]       cursor_y,
  input  logic [srle_pkg::BYTE_W-1:0] code_byte,
  input  logic                        final_byte,
  output logic [srle_pkg::MODE_W-1:0] mode_next,
  output logic [srle_pkg::BYTE_W-1:0] pend_next,
  output logic [COORD_BITS-1:0]       cursor_x_next,
  output logic [COORD_BITS-1:0]       cursor_y_next,
  output srle_pkg::res_t              res,
  output srle_pkg::ctl_t              ctl
);

  logic [srle_pkg::KIND_W-1:0] kind;
  logic [srle_pkg::BYTE_W-1:0] len;
  logic [srle_pkg::BYTE_W-1:0] col;
  logic [srle_pkg::MODE_W-1:0] mode_d;
  logic [srle_pkg::BYTE_W-1:0] pend_d;
  logic                        newline;
  logic                        end_code;
  logic                        skip;
  logic                        have;
  logic                        close;
  logic [srle_pkg::BYTE_W-1:0] x_amt;
  logic [COORD_BITS:0]         sum_x;
  logic [COORD_BITS:0]         sum_y;
  logic [COORD_BITS-1:0]       sat_x;
  logic [COORD_BITS-1:0]       sat_y;
  logic [COORD_BITS-1:0]       cx_upd;
  logic [COORD_BITS-1:0]       cy_upd;

  always_comb begin
    kind     = srle_pkg::KIND_COLOUR;
    len      = '0;
    col      = '0;
    mode_d   = mode;
    pend_d   = pend;
    newline  = 1'b0;
    end_code = 1'b0;
    skip     = 1'b0;
    case (mode)
      srle_pkg::MODE_LIT: begin
        len = 8'd1;
        col = code_byte;
        if (pend <= 8'd1) begin
          pend_d = '0;
          mode_d = srle_pkg::MODE_CMD;
        end else begin
          pend_d = pend - 8'd1;
        end
      end
      srle_pkg::MODE_SH_FIRST: begin
        if (code_byte[1:0] != 2'd0) begin
          kind   = srle_pkg::KIND_SHADOW;
          len    = {6'd0, code_byte[1:0]};
          mode_d = srle_pkg::MODE_CMD;
        end else begin
          mode_d = srle_pkg::MODE_SH_COUNT;
        end
      end
      srle_pkg::MODE_SH_COUNT: begin
        kind   = srle_pkg::KIND_SHADOW;
        len    = code_byte;
        mode_d = srle_pkg::MODE_CMD;
      end
      srle_pkg::MODE_CNT_COLOUR: begin
        pend_d = code_byte;
        mode_d = srle_pkg::MODE_REPEAT;
      end
      srle_pkg::MODE_REPEAT: begin
        len    = pend;
        col    = code_byte;
        pend_d = '0;
        mode_d = srle_pkg::MODE_CMD;
      end
      default: begin
        mode_d = srle_pkg::MODE_CMD;
        if (code_byte == srle_pkg::CODE_NEWLINE) begin
          newline = 1'b1;
        end else if (code_byte inside {[8'h01:8'h7F]}) begin
          pend_d = code_byte;
          mode_d = srle_pkg::MODE_LIT;
        end else if (code_byte == srle_pkg::CODE_END) begin
          end_code = 1'b1;
        end else if (code_byte inside {[8'h81:8'hBF]}) begin
          skip = 1'b1;
        end else if (code_byte == srle_pkg::CODE_SHADOW) begin
          mode_d = srle_pkg::MODE_SH_FIRST;
        end else if (code_byte == srle_pkg::CODE_CNT_COLOUR) begin
          mode_d = srle_pkg::MODE_CNT_COLOUR;
        end else begin
          pend_d = code_byte - srle_pkg::CODE_SHADOW;
          mode_d = srle_pkg::MODE_REPEAT;
        end
      end
    endcase
  end

  assign have  = (len != '0);
  assign x_amt = skip ? (code_byte - srle_pkg::CODE_END) : len;
  assign sum_x = {1'b0, cursor_x} + (COORD_BITS+1)'(x_amt);
  assign sum_y = {1'b0, cursor_y} + (COORD_BITS+1)'(1'b1);
  assign sat_x = sum_x[COORD_BITS] ? '1 : sum_x[COORD_BITS-1:0];
  assign sat_y = sum_y[COORD_BITS] ? '1 : sum_y[COORD_BITS-1:0];

  // cursor after this byte, before any sprite close
  assign cx_upd = newline ? '0 : ((have | skip) ? sat_x : cursor_x);
  assign cy_upd = newline ? sat_y : cursor_y;

  assign close = end_code | final_byte;
  assign ctl   = {have | close, close};

  always_comb begin
    if (close) begin
      mode_next     = srle_pkg::MODE_CMD;
      pend_next     = '0;
      cursor_x_next = '0;
      cursor_y_next = '0;
    end else begin
      mode_next     = mode_d;
      pend_next     = pend_d;
      cursor_x_next = cx_upd;
      cursor_y_next = cy_upd;
    end
  end

  always_comb begin
    res.truncated   = final_byte & ~end_code;
    res.sprite_done = close;
    if (have) begin
      res.start_x      = srle_pkg::COORD_W'(cursor_x);
      res.start_y      = srle_pkg::COORD_W'(cursor_y);
      res.run_kind     = kind;
      res.run_length   = len;
      res.colour_index = col;
    end else begin
      // end result sits at the cursor left by a line or skip code
      res.start_x      = srle_pkg::COORD_W'(cx_upd);
      res.start_y      = srle_pkg::COORD_W'(cy_upd);
      res.run_kind     = srle_pkg::KIND_END;
      res.run_length   = '0;
      res.colour_index = '0;
    end
  end

endmodule

// ===== rtl/core/sprite_rle_run_decoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_rle_run_decoder_top
// Decodes a run-length sprite byte stream into pixel runs.
//
//   channel  handshake            payload
//   in       in_valid / in_ready   code_byte, final_byte
//   out      out_valid / out_ready run_kind, start_x, start_y, run_length,
//                                  colour_index, truncated, sprite_done
//
// one byte per cycle while in_ready is high; a run appears at the output in the
// cycle after its byte is accepted; the result register is the only pipeline
// stage, and decode state updates on every accepted byte
// in_ready drops only while a result is held and out_ready is low
// reset returns the decoder to command mode at cursor (0, 0) and empties
// the result register
// ----------------------------------------------------------------------------
module sprite_rle_run_decoder_top #(
  parameter int COORD_BITS = srle_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [srle_pkg::BYTE_W-1:0]  code_byte,
  input  logic                         final_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [srle_pkg::KIND_W-1:0]  run_kind,
  output logic [srle_pkg::COORD_W-1:0] start_x,
  output logic [srle_pkg::COORD_W-1:0] start_y,
  output logic [srle_pkg::BYTE_W-1:0]  run_length,
  output logic [srle_pkg::BYTE_W-1:0]  colour_index,
  output logic                         truncated,
  output logic                         sprite_done
);

  logic [srle_pkg::MODE_W-1:0] mode;
  logic [srle_pkg::MODE_W-1:0] mode_next;
  logic [srle_pkg::BYTE_W-1:0] pend;
  logic [srle_pkg::BYTE_W-1:0] pend_next;
  logic [COORD_BITS-1:0]       cursor_x;
  logic [COORD_BITS-1:0]       cursor_x_next;
  logic [COORD_BITS-1:0]       cursor_y;
  logic [COORD_BITS-1:0]       cursor_y_next;
  srle_pkg::res_t              res_next;
  srle_pkg::res_t              res;
  srle_pkg::ctl_t              ctl;
  logic                        accept;

  assign in_ready = ~out_valid | out_ready;
  assign accept   = in_valid & in_ready;

  srle_decode #(
    .COORD_BITS(COORD_BITS)
  ) u_decode (
    .mode          (mode),
    .pend          (pend),
    .cursor_x      (cursor_x),
    .cursor_y      (cursor_y),
    .code_byte     (code_byte),
    .final_byte    (final_byte),
    .mode_next     (mode_next),
    .pend_next     (pend_next),
    .cursor_x_next (cursor_x_next),
    .cursor_y_next (cursor_y_next),
    .res           (res_next),
    .ctl           (ctl)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= srle_pkg::MODE_CMD;
      pend     <= '0;
      cursor_x <= '0;
      cursor_y <= '0;
    end else if (accept) begin
      mode     <= mode_next;
      pend     <= pend_next;
      cursor_x <= cursor_x_next;
      cursor_y <= cursor_y_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && ctl.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && ctl.emit) begin
      res <= res_next;
    end
  end

  assign run_kind     = res.run_kind;
  assign start_x      = res.start_x;
  assign start_y      = res.start_y;
  assign run_length   = res.run_length;
  assign colour_index = res.colour_index;
  assign truncated    = res.truncated;
  assign sprite_done  = res.sprite_done;

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result register not empty after reset");

  a_close_resets: assert property (@(posedge clk) disable iff (rst)
    accept && ctl.close |=> mode == srle_pkg::MODE_CMD && pend == '0 &&
      cursor_x == '0 && cursor_y == '0)
    else $error("decoder state not cleared after sprite close");

  a_end_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && run_kind == srle_pkg::KIND_END |->
      run_length == '0 && colour_index == '0 && sprite_done)
    else $error("bad end result fields");

  a_run_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && run_kind != srle_pkg::KIND_END |-> run_length != '0)
    else $error("pixel run of zero length");

  a_trunc_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && truncated |-> sprite_done)
    else $error("truncated result does not close the sprite");
`endif

endmodule
